[rtl/core/pqa_pkg.sv]
package pqa_pkg;
  localparam int MAX_TASKS_DEF    = 16;
  localparam int NUM_LEVELS_DEF   = 4;
  localparam int AGING_PERIOD_DEF = 5;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_AGE      = 2'd1;
  localparam logic [1:0] OP_REMOVE   = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADLEVEL = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // one task entry as held in the slot memory
  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] arrival;
    logic [2:0]  level;
  } entry_t;
endpackage

[rtl/core/priority_queue_with_aging_top.sv]
// channel | dir | tuser          | tdata, low bit first
// s_axis  | in  | operation[1:0] | task_id[7:0] arrival_time[23:8] priority_level[26:24]
//         |     |                |   current_time[42:27], zero fill to 48 bits
// m_axis  | out | none           | top_valid[0] top_task_id[8:1] top_level[11:9]
//         |     |                |   status[13:12], zero fill to 16 bits
// passes per op: add or unused op one search pass, aging tick an aging pass then a search pass,
// remove two search passes; the slot memory is walked one entry a cycle per pass
// an add's result is registered in the done state after its single search pass
// rst synchronous active high, clears valid bits and control state (FSM, counter, flags, m_tvalid) only
// one transaction in flight; a result not yet taken holds the next one in its done state
module priority_queue_with_aging_top #(
  parameter int MAX_TASKS    = pqa_pkg::MAX_TASKS_DEF,
  parameter int NUM_LEVELS   = pqa_pkg::NUM_LEVELS_DEF,
  parameter int AGING_PERIOD = pqa_pkg::AGING_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,  // operation
  input  logic [47:0] s_tdata,  // task_id, arrival_time, priority_level, current_time
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // top_valid, top_task_id, top_level, status
);
  import pqa_pkg::*;
  logic [13:0] res;

  pqa_ctrl #(.MAX_TASKS(MAX_TASKS), .NUM_LEVELS(NUM_LEVELS),
             .AGING_PERIOD(AGING_PERIOD)) u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .op(s_tuser), .task_id(s_tdata[7:0]), .arrival_time(s_tdata[23:8]),
    .priority_level(s_tdata[26:24]), .current_time(s_tdata[42:27]),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(res)
  );

  assign m_tdata = {2'b00, res};
endmodule

[rtl/core/pqa_mem.sv]
module pqa_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pqa_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output pqa_pkg::entry_t rdata
);
  import pqa_pkg::*;
  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/pqa_ctrl.sv]
module pqa_ctrl #(
  parameter int MAX_TASKS    = 16,
  parameter int NUM_LEVELS   = 4,
  parameter int AGING_PERIOD = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  op,
  input  logic [7:0]  task_id,
  input  logic [15:0] arrival_time,
  input  logic [2:0]  priority_level,
  input  logic [15:0] current_time,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [13:0] m_res
);
  import pqa_pkg::*;
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_TASKS);
  // ceil(2^32 / period), used for the divisibility test
  localparam logic [32:0] AGE_MUL =
    33'(((64'd1 << 32) + 64'(AGING_PERIOD) - 64'd1) / 64'(AGING_PERIOD));

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_AGE = 4'b0010, S_FIND = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t state;
  logic [MAX_TASKS-1:0] valid;
  logic [15:0] now_r;
  logic [1:0]  status;
  logic [CW-1:0] cnt;
  logic remove_pass;
  logic best_found;
  logic [AW-1:0] best_idx;
  entry_t best;

  logic we;
  logic [AW-1:0] waddr, raddr, ridx;
  entry_t wdata, rdata;

  pqa_mem #(.DEPTH(MAX_TASKS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // lowest free slot
  logic free_found;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  // entry read this cycle was addressed last cycle
  assign ridx = AW'(cnt - CW'(1));
  assign raddr = cnt[AW-1:0];

  // aging check: entry valid, level 2 or higher, and |now - arrival| nonzero multiple of period
  // a multiple leaves a fractional part of mag * AGE_MUL below AGE_MUL
  logic [15:0] mag;
  logic [31:0] age_prod;
  logic promote;
  always_comb begin
    mag = (now_r >= rdata.arrival) ? now_r - rdata.arrival : rdata.arrival - now_r;
    age_prod = 32'({33'd0, mag} * {16'd0, AGE_MUL});
    promote = valid[ridx] && (rdata.level >= 3'd2) && (mag != 16'd0) &&
              ({1'b0, age_prod} < AGE_MUL);
  end

  logic better;
  assign better = valid[ridx] && (!best_found || rdata.level < best.level ||
                  (rdata.level == best.level && rdata.arrival < best.arrival));

  logic bad_level;
  assign bad_level = (priority_level == 3'd0) ||
                     ({1'b0, priority_level} > 4'(NUM_LEVELS));

  always_comb begin
    we = 1'b0;
    waddr = free_idx;
    wdata.task_id = task_id;
    wdata.arrival = arrival_time;
    wdata.level = priority_level;
    if (state == S_IDLE) begin
      we = s_tvalid && s_tready && op == OP_ADD && !bad_level && free_found;
    end else if (state == S_AGE && cnt != '0) begin
      we = promote;
      waddr = ridx;
      wdata = rdata;
      wdata.level = rdata.level - 3'd1;
    end
  end

  assign s_tready = (state == S_IDLE);

  // final done state (not the first pass of a remove) and result register free or being drained this cycle
  logic emit;
  assign emit = (state == S_DONE) && !remove_pass && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      m_tvalid <= 1'b0;
      cnt <= '0;
      best_found <= 1'b0;
      remove_pass <= 1'b0;
    end else begin
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          best_found <= 1'b0;
          if (s_tvalid && s_tready) begin
            now_r <= current_time;
            remove_pass <= (op == OP_REMOVE);
            state <= (op == OP_AGE) ? S_AGE : S_FIND;
            priority if (op == OP_ADD && bad_level) status <= ST_BADLEVEL;
            else if (op == OP_ADD && !free_found) status <= ST_FULL;
            else status <= ST_OK;
            if (op == OP_ADD && !bad_level && free_found) valid[free_idx] <= 1'b1;
          end
        end
        S_AGE: begin
          if (cnt == LAST) begin
            cnt <= '0;
            state <= S_FIND;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        S_FIND: begin
          cnt <= cnt + CW'(1);
          if (cnt != '0 && better) begin
            best_found <= 1'b1;
            best_idx <= ridx;
            best <= rdata;
          end
          if (cnt == LAST) state <= S_DONE;
        end
        S_DONE: begin
          if (remove_pass) begin
            // drop the top, then search again
            remove_pass <= 1'b0;
            cnt <= '0;
            best_found <= 1'b0;
            state <= S_FIND;
            if (best_found) valid[best_idx] <= 1'b0;
            else status <= ST_EMPTY;
          end else if (emit) begin
            m_res <= {status, best_found ? best.level : 3'd0,
                      best_found ? best.task_id : 8'd0, best_found};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
